@@ design/wildcard_glob_matcher_unit_macros.svh @@
// Assertion macros for the wildcard glob matcher.
// Uses clk and arst_n of the module that includes this header.
`ifndef WILDCARD_GLOB_MATCHER_UNIT_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_UNIT_MACROS_SVH

// check cons in the same cycle as ante
`define WGM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wgm same-cycle check failed");

// check cons in the cycle after ante
`define WGM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wgm next-cycle check failed");

`endif

@@ design/wgm_pkg.sv @@
// Package for the wildcard glob matcher: default sizes, character codes,
// request kinds and the step control struct. No dependencies.
`timescale 1ns / 1ps

package wgm_pkg;

	localparam int MAX_PATTERN_DEF = 32;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	typedef enum logic {
		REQ_PATTERN = 1'b0,
		REQ_SUBJECT = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       carries_char;
		logic       case_sensitive;
	} step_ctrl_t;

endpackage

@@ design/wgm_nfa.sv @@
// One character step of the glob NFA over all pattern positions.
// Depends on wgm_pkg for character codes and the step control struct.
`timescale 1ns / 1ps

module wgm_nfa #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
	input  logic [7:0]                         pattern [MAX_PATTERN],
	input  logic [$clog2(MAX_PATTERN+1)-1:0]   pat_len,
	input  logic [MAX_PATTERN:0]               active,
	input  logic                               fresh,
	input  wgm_pkg::step_ctrl_t                ctrl,
	output logic [MAX_PATTERN:0]               step_vec
);

	localparam int W     = MAX_PATTERN + 1;
	localparam int LW    = $clog2(W);
	localparam int STEPS = $clog2(W);

	logic [W-1:0] star_m;
	logic [W-1:0] hit_m;
	logic [W-1:0] cur;
	logic [W-1:0] raw;
	logic [7:0]   c_fold;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
		if (!cs && (c inside {[8'h41:8'h5A]})) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	// spread activity across runs of stars, prefix style
	function automatic logic [W-1:0] star_closure(input logic [W-1:0] g_in,
		input logic [W-1:0] p_in);
		logic [W-1:0] g;
		logic [W-1:0] p;
		g = g_in;
		p = p_in;
		for (int k = 0; k < STEPS; k++) begin
			g = g | ((g & p) << (1 << k));
			p = p & (p >> (1 << k));
		end
		return g;
	endfunction

	always_comb begin
		c_fold = fold(ctrl.char_code, ctrl.case_sensitive);
		star_m = '0;
		hit_m  = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (LW'(i) < pat_len) begin
				star_m[i] = (pattern[i] == wgm_pkg::CH_STAR);
				hit_m[i]  = (pattern[i] != wgm_pkg::CH_STAR) &&
					((pattern[i] == wgm_pkg::CH_QMARK) ||
					 (fold(pattern[i], ctrl.case_sensitive) == c_fold));
			end
		end
		cur      = fresh ? star_closure(W'(1), star_m) : active;
		raw      = (cur & star_m) | ((cur & hit_m) << 1);
		step_vec = ctrl.carries_char ? star_closure(raw, star_m) : cur;
	end

endmodule

@@ design/wildcard_glob_matcher_unit.sv @@
// Each accepted item is held in the input register and processed there; the
// result of a final subject item then goes to the result register. Throughput:
// one item per cycle unless a result stalls, via the NFA update around active_q.
// Reset (arst_n low, asynchronous): no pattern, no overflow, case_sensitive = 1,
// empty channels; pattern store contents undefined until written.
// Top level of the wildcard glob matcher. Depends on wgm_pkg, wgm_nfa and
// wildcard_glob_matcher_unit_macros.svh.
`timescale 1ns / 1ps
`include "wildcard_glob_matcher_unit_macros.svh"

module wildcard_glob_matcher_unit #(
	parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] char_code,
	input  logic       carries_char,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       matched,
	output logic       pattern_overflow
);

	localparam int W  = MAX_PATTERN + 1;
	localparam int LW = $clog2(W);
	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic                case_sens_q;
	logic                valid_s1;
	wgm_pkg::req_kind_t  req_s1;
	logic [7:0]          char_s1;
	logic                has_s1;
	logic                last_s1;

	logic [7:0]          store_q [MAX_PATTERN];
	logic [LW-1:0]       len_q;
	logic                ovf_q;
	logic                closed_q;
	logic                fresh_q;
	logic [W-1:0]        active_q;

	logic                out_valid_q;
	logic                matched_q;
	logic                ovf_out_q;

	logic                result_s1;
	logic                go_s1;
	logic                load_s1;
	logic [LW-1:0]       base_len;
	logic                base_ovf;
	logic                room;
	logic [W-1:0]        step_vec;
	wgm_pkg::step_ctrl_t ctrl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_sens_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case_sens_q <= cfg_data;
		end
	end

	assign result_s1 = valid_s1 && (req_s1 == wgm_pkg::REQ_SUBJECT) && last_s1;
	assign go_s1     = valid_s1 && (!result_s1 || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || go_s1;
	assign load_s1   = go_s1 && (req_s1 == wgm_pkg::REQ_PATTERN);

	assign base_len = closed_q ? '0 : len_q;
	assign base_ovf = closed_q ? 1'b0 : ovf_q;
	assign room     = (base_len < LW'(MAX_PATTERN));

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= wgm_pkg::req_kind_t'(req_type);
			char_s1 <= char_code;
			has_s1  <= carries_char;
			last_s1 <= is_last;
		end
	end

	// pattern store
	always_ff @(posedge clk) begin
		if (load_s1 && has_s1 && room) begin
			store_q[base_len[IW-1:0]] <= char_s1;
		end
	end

	assign ctrl.char_code      = char_s1;
	assign ctrl.carries_char   = has_s1;
	assign ctrl.case_sensitive = case_sens_q;

	wgm_nfa #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_nfa (
		.pattern (store_q),
		.pat_len (len_q),
		.active  (active_q),
		.fresh   (fresh_q),
		.ctrl    (ctrl),
		.step_vec(step_vec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			ovf_q    <= 1'b0;
			closed_q <= 1'b1;
			fresh_q  <= 1'b1;
			active_q <= '0;
		end else if (go_s1) begin
			if (req_s1 == wgm_pkg::REQ_PATTERN) begin
				len_q    <= base_len;
				ovf_q    <= base_ovf;
				if (has_s1) begin
					if (room) begin
						len_q <= base_len + LW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				closed_q <= last_s1;
				fresh_q  <= 1'b1;
			end else begin
				closed_q <= 1'b1;
				if (last_s1) begin
					fresh_q <= 1'b1;
				end else if (has_s1) begin
					active_q <= step_vec;
					fresh_q  <= 1'b0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && result_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && result_s1) begin
			matched_q <= !ovf_q && step_vec[len_q];
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = ovf_out_q;

	`WGM_ASSERT_NOW(a_ovf_no_match, out_valid && pattern_overflow, !matched)
	`WGM_ASSERT_NOW(a_ovf_full, ovf_q, len_q == LW'(MAX_PATTERN))
	`WGM_ASSERT_NOW(a_stall_cause, !in_ready, valid_s1 && out_valid_q && !out_ready)
	`WGM_ASSERT_NEXT(a_restart_after_result, go_s1 && result_s1, fresh_q && out_valid_q)

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for wildcard_glob_matcher_unit: streams patterns and subjects, predicts each
// match verdict in a scoreboard class and checks every result in order.
// Depends on wgm_pkg and the wildcard_glob_matcher_unit RTL.

module tb_top;

	typedef struct {
		bit matched;
		bit overflow;
	} glob_verdict_t;

	typedef bit [7:0] char_q_t [$];

	class glob_scoreboard;
		localparam int DEPTH = wgm_pkg::MAX_PATTERN_DEF;

		bit            case_sens;
		bit [7:0]      store [DEPTH];
		int unsigned   plen;
		bit [DEPTH:0]  active;
		bit            ovf;
		bit            closed;
		glob_verdict_t verdicts [$];
		int            fail_count;

		function new();
			case_sens = 1'b1;
			plen = 0;
			ovf = 1'b0;
			closed = 1'b1;
			fail_count = 0;
			restart();
		endfunction

		function void set_case(bit v);
			case_sens = v;
		endfunction

		function int pending();
			return verdicts.size();
		endfunction

		function bit [7:0] fold(bit [7:0] c);
			if (!case_sens && c >= 8'h41 && c <= 8'h5A) begin
				return c + 8'h20;
			end
			return c;
		endfunction

		function bit [DEPTH:0] star_closure(bit [DEPTH:0] v);
			for (int i = 0; i < plen; i++) begin
				if (v[i] && store[i] == wgm_pkg::CH_STAR) begin
					v[i + 1] = 1'b1;
				end
			end
			return v;
		endfunction

		function void restart();
			active = star_closure({{DEPTH{1'b0}}, 1'b1});
		endfunction

		function void advance(bit [7:0] ch);
			bit [DEPTH:0] nxt;
			bit [7:0]     c;
			nxt = '0;
			c = fold(ch);
			for (int i = 0; i < plen; i++) begin
				if (active[i]) begin
					if (store[i] == wgm_pkg::CH_STAR) begin
						nxt[i] = 1'b1;
					end else if (store[i] == wgm_pkg::CH_QMARK
							|| fold(store[i]) == c) begin
						nxt[i + 1] = 1'b1;
					end
				end
			end
			active = star_closure(nxt);
		endfunction

		function void note_item(wgm_pkg::req_kind_t kind, bit [7:0] ch, bit has, bit last);
			glob_verdict_t v;
			if (kind == wgm_pkg::REQ_PATTERN) begin
				if (closed) begin
					plen = 0;
					ovf = 1'b0;
					closed = 1'b0;
				end
				if (has) begin
					if (plen < DEPTH) begin
						store[plen] = ch;
						plen++;
					end else begin
						ovf = 1'b1;
					end
				end
				if (last) begin
					closed = 1'b1;
				end
				restart();
				return;
			end
			closed = 1'b1;
			if (has) begin
				advance(ch);
			end
			if (last) begin
				v.matched = !ovf && active[plen];
				v.overflow = ovf;
				verdicts.push_back(v);
				restart();
			end
		endfunction

		task report_mismatch(string msg);
			$display("mismatch: %s", msg);
			fail_count++;
		endtask

		task check_result(logic m, logic o);
			glob_verdict_t want;
			if (verdicts.size() == 0) begin
				report_mismatch("result with no item outstanding");
				return;
			end
			want = verdicts.pop_front();
			if (m !== want.matched) begin
				report_mismatch($sformatf("matched got %b want %b", m, want.matched));
			end
			if (o !== want.overflow) begin
				report_mismatch($sformatf("pattern_overflow got %b want %b", o, want.overflow));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       req_type = 1'b0;
	logic [7:0] char_code = 8'h00;
	logic       carries_char = 1'b0;
	logic       is_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       matched;
	logic       pattern_overflow;

	glob_scoreboard sb = new();

	bit src_gaps = 1'b1;
	bit dst_gaps = 1'b1;
	bit long_hold = 1'b0;
	int sent_count = 0;

	wildcard_glob_matcher_unit u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.char_code        (char_code),
		.carries_char     (carries_char),
		.is_last          (is_last),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.matched          (matched),
		.pattern_overflow (pattern_overflow)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(400_000 * 20);
		$display("FAILURE");
		$finish;
	end

	function automatic int draw_gap(bit enabled);
		return enabled ? $urandom_range(0, 10) : 0;
	endfunction

	function automatic bit [7:0] pick_plain();
		bit [7:0] set [8] = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h5A, 8'h7A, 8'h40, 8'h5B};
		if ($urandom_range(0, 9) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		return set[$urandom_range(0, 7)];
	endfunction

	function automatic bit [7:0] pick_pattern_char();
		case ($urandom_range(0, 9))
			0, 1: return wgm_pkg::CH_STAR;
			2: return wgm_pkg::CH_QMARK;
			default: return pick_plain();
		endcase
	endfunction

	function automatic char_q_t build_pattern(bit force_long);
		char_q_t p;
		int      len;
		int      r;
		r = $urandom_range(0, 99);
		if (force_long || r < 5) begin
			len = $urandom_range(33, 40);
		end else if (r < 15) begin
			len = 0;
		end else begin
			len = $urandom_range(1, 8);
		end
		repeat (len) p.push_back(pick_pattern_char());
		return p;
	endfunction

	function automatic char_q_t build_subject(char_q_t p);
		char_q_t s;
		int      pos;
		foreach (p[i]) begin
			if (p[i] == wgm_pkg::CH_STAR) begin
				repeat ($urandom_range(0, 3)) s.push_back(pick_plain());
			end else if (p[i] == wgm_pkg::CH_QMARK) begin
				s.push_back(8'($urandom_range(0, 255)));
			end else if ((p[i] | 8'h20) >= 8'h61 && (p[i] | 8'h20) <= 8'h7A
					&& $urandom_range(0, 1)) begin
				s.push_back(p[i] ^ 8'h20);
			end else begin
				s.push_back(p[i]);
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			pos = $urandom_range(0, s.size());
			case ($urandom_range(0, 2))
				0: if (s.size() > 0) s.delete(pos == s.size() ? pos - 1 : pos);
				1: s.insert(pos, pick_plain());
				default: if (pos < s.size()) s[pos] = pick_plain();
			endcase
		end
		return s;
	endfunction

	task automatic send_item(wgm_pkg::req_kind_t kind, bit [7:0] ch, bit has, bit last);
		int gap;
		gap = draw_gap(src_gaps);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		char_code <= ch;
		carries_char <= has;
		is_last <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_item(kind, ch, has, last);
		sent_count++;
	endtask

	task automatic send_string(wgm_pkg::req_kind_t kind, char_q_t s);
		if (s.size() == 0) begin
			send_item(kind, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end else begin
			foreach (s[i]) send_item(kind, s[i], 1'b1, i == s.size() - 1);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_case(bit v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_case(v);
	endtask

	task automatic run_sequences(int target, bit force_long);
		char_q_t pat;
		int      r;
		while (sent_count < target) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				send_item(wgm_pkg::req_kind_t'(1'($urandom_range(0, 1))),
					8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				pat = build_pattern(force_long);
				force_long = 1'b0;
				send_string(wgm_pkg::REQ_PATTERN, pat);
				repeat ($urandom_range(1, 3))
					send_string(wgm_pkg::REQ_SUBJECT, build_subject(pat));
			end
		end
		send_item(wgm_pkg::REQ_SUBJECT, 8'h00, 1'b0, 1'b1);
	endtask

	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int gap;
			if (long_hold) begin
				long_hold = 1'b0;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				gap = draw_gap(dst_gaps);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(matched, pattern_overflow);
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_case(1'b1);

		send_item(wgm_pkg::REQ_SUBJECT, 8'hFF, 1'b0, 1'b1);
		send_string(wgm_pkg::REQ_PATTERN, '{8'h41, wgm_pkg::CH_STAR, wgm_pkg::CH_QMARK, 8'h63});
		send_string(wgm_pkg::REQ_SUBJECT, '{8'h41, 8'h78, 8'h79, 8'h63});
		send_string(wgm_pkg::REQ_SUBJECT, '{8'h41, 8'h63});
		send_string(wgm_pkg::REQ_PATTERN, '{8'hFF, 8'h00});
		send_string(wgm_pkg::REQ_SUBJECT, '{8'hFF, 8'h00});
		send_item(wgm_pkg::REQ_PATTERN, 8'h00, 1'b0, 1'b1);
		send_item(wgm_pkg::REQ_SUBJECT, 8'h78, 1'b1, 1'b1);
		send_item(wgm_pkg::REQ_SUBJECT, 8'h71, 1'b1, 1'b0);
		send_item(wgm_pkg::REQ_PATTERN, wgm_pkg::CH_STAR, 1'b1, 1'b1);
		send_item(wgm_pkg::REQ_SUBJECT, 8'h00, 1'b0, 1'b1);
		write_case(1'b0);
		send_item(wgm_pkg::REQ_PATTERN, 8'h62, 1'b1, 1'b1);
		send_item(wgm_pkg::REQ_SUBJECT, 8'h42, 1'b1, 1'b1);

		for (int ph = 0; ph < 6; ph++) begin
			write_case(1'(ph % 2));
			src_gaps = (ph != 2);
			dst_gaps = (ph != 3);
			if (ph == 1) begin
				src_gaps = 1'b0;
				long_hold = 1'b1;
				repeat (40) send_item(wgm_pkg::REQ_SUBJECT, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'b1);
				src_gaps = 1'b1;
			end
			run_sequences(sent_count + 140, ph == 0);
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (sb.fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/wgm_pkg.sv
design/wgm_nfa.sv
design/wildcard_glob_matcher_unit.sv
verif/tb_top.sv
